[hdl/wmv_pkg.sv]
package wmv_pkg;

    localparam int SAMPLE_W = 16;
    localparam int MEAN_W   = 24;
    localparam int VAR_W    = 30;
    localparam int CHANNELS = 3;
    localparam int DIGIT_W  = 8;
    localparam int FRAC_W   = 8;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [MEAN_W-1:0]   mean_t;
    typedef logic [VAR_W-1:0]    var_t;

    typedef struct packed {
        logic capture;
        logic update;
        logic div_step;
        logic qr_load;
        logic sq_load;
        logic t_load;
        logic out_load;
    } wmv_cmd_t;

endpackage

[hdl/wmv_if.sv]
interface wmv_in_if;
    import wmv_pkg::*;

    logic    valid;
    logic    ready;
    sample_t light_sample;
    sample_t temp_sample;
    sample_t noise_sample;

    modport source (output valid, output light_sample, output temp_sample,
                    output noise_sample, input ready);
    modport sink (input valid, input light_sample, input temp_sample,
                  input noise_sample, output ready);
endinterface

interface wmv_out_if;
    import wmv_pkg::*;

    logic  valid;
    logic  ready;
    mean_t light_mean;
    mean_t temp_mean;
    mean_t noise_mean;
    var_t  light_variance;
    var_t  temp_variance;
    var_t  noise_variance;

    modport source (output valid, output light_mean, output temp_mean, output noise_mean,
                    output light_variance, output temp_variance, output noise_variance,
                    input ready);
    modport sink (input valid, input light_mean, input temp_mean, input noise_mean,
                  input light_variance, input temp_variance, input noise_variance,
                  output ready);
endinterface

[hdl/wmv_ram.sv]
module wmv_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 20
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/wmv_cdiv.sv]
module wmv_cdiv #(
    parameter int DIVISOR = 20,
    parameter int NUM_W   = 37
) (
    input  logic                       clk,
    input  logic                       load,
    input  logic                       step,
    input  logic [NUM_W-1:0]           load_value,
    output logic [NUM_W-1:0]           quotient,
    output logic [$clog2(DIVISOR)-1:0] remainder
);
    import wmv_pkg::*;

    localparam int REM_W = $clog2(DIVISOR);
    localparam int ND    = (NUM_W + DIGIT_W - 1) / DIGIT_W;
    localparam int SH_W  = ND * DIGIT_W;

    logic [SH_W-1:0]    num_reg;
    logic [NUM_W-1:0]   quo_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [REM_W-1:0]   rem_next;
    logic [DIGIT_W-1:0] qdigit;

    always_comb
    begin
        logic [DIGIT_W-1:0] digit;
        logic [REM_W:0]     trial;
        logic [REM_W-1:0]   r;
        digit  = num_reg[SH_W-1 -: DIGIT_W];
        r      = rem_reg;
        qdigit = '0;
        for (int i = DIGIT_W - 1; i >= 0; i--)
        begin
            trial = {r, digit[i]};
            if (trial >= (REM_W+1)'(DIVISOR))
            begin
                trial     = trial - (REM_W+1)'(DIVISOR);
                qdigit[i] = 1'b1;
            end
            r = trial[REM_W-1:0];
        end
        rem_next = r;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            num_reg <= SH_W'(load_value);
            quo_reg <= '0;
            rem_reg <= '0;
        end
        else if (step)
        begin
            num_reg <= {num_reg[SH_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            quo_reg <= {quo_reg[NUM_W-DIGIT_W-1:0], qdigit};
            rem_reg <= rem_next;
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

[hdl/wmv_ctrl.sv]
module wmv_ctrl #(
    parameter int WINDOW = 20
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output wmv_pkg::wmv_cmd_t cmd
);
    import wmv_pkg::*;

    localparam int SQ_W  = 2 * SAMPLE_W + $clog2(WINDOW);
    localparam int ND    = (SQ_W + DIGIT_W - 1) / DIGIT_W;
    localparam int CNT_W = $clog2(ND);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_UPD   = 3'd1;
    localparam logic [2:0] S_MDIV  = 3'd2;
    localparam logic [2:0] S_QR    = 3'd3;
    localparam logic [2:0] S_SQ    = 3'd4;
    localparam logic [2:0] S_TLOAD = 3'd5;
    localparam logic [2:0] S_TDIV  = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_UPD;
                end
            end
            S_UPD:
            begin
                cmd.update = 1'b1;
                cnt_next   = '0;
                state_next = S_MDIV;
            end
            S_MDIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CNT_W'(ND - 1))
                begin
                    state_next = S_QR;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_QR:
            begin
                cmd.qr_load = 1'b1;
                state_next  = S_SQ;
            end
            S_SQ:
            begin
                cmd.sq_load = 1'b1;
                state_next  = S_TLOAD;
            end
            S_TLOAD:
            begin
                cmd.t_load = 1'b1;
                cnt_next   = '0;
                state_next = S_TDIV;
            end
            S_TDIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CNT_W'(ND - 1))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result loaded over a pending transaction");

    a_accept_updates: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_UPD))
        else $error("accepted transaction not followed by window update");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(ND - 1))
        else $error("digit counter out of range");

    a_idle_no_step: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !cmd.div_step)
        else $error("divider stepping while idle");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("loaded result not presented");

endmodule

[hdl/wmv_dp.sv]
module wmv_dp #(
    parameter int WINDOW = 20
) (
    input  logic              clk,
    input  logic              rst_n,
    input  wmv_pkg::wmv_cmd_t cmd,
    input  wmv_pkg::sample_t  light_sample,
    input  wmv_pkg::sample_t  temp_sample,
    input  wmv_pkg::sample_t  noise_sample,
    output wmv_pkg::mean_t    light_mean,
    output wmv_pkg::mean_t    temp_mean,
    output wmv_pkg::mean_t    noise_mean,
    output wmv_pkg::var_t     light_variance,
    output wmv_pkg::var_t     temp_variance,
    output wmv_pkg::var_t     noise_variance
);
    import wmv_pkg::*;

    localparam int L      = $clog2(WINDOW);
    localparam int SUM_W  = SAMPLE_W + L;
    localparam int SQ_W   = 2 * SAMPLE_W + L;
    localparam int WORD_W = CHANNELS * SAMPLE_W;

    logic [L-1:0]        slot_reg;
    logic [WINDOW-1:0]   valid_reg;
    logic                old_valid_reg;
    sample_t             new_reg [CHANNELS];
    logic [WORD_W-1:0]   wdata;
    logic [WORD_W-1:0]   rdata;
    mean_t               mean_out_reg [CHANNELS];
    var_t                var_out_reg [CHANNELS];

    assign wdata = {new_reg[2], new_reg[1], new_reg[0]};

    wmv_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WINDOW)
    ) u_window (
        .clk   (clk),
        .we    (cmd.update),
        .waddr (slot_reg),
        .wdata (wdata),
        .raddr (slot_reg),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= '0;
            valid_reg     <= '0;
            old_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                old_valid_reg <= valid_reg[slot_reg];
            end
            if (cmd.update)
            begin
                valid_reg[slot_reg] <= 1'b1;
                if (slot_reg == L'(WINDOW - 1))
                begin
                    slot_reg <= '0;
                end
                else
                begin
                    slot_reg <= slot_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            new_reg[0] <= light_sample;
            new_reg[1] <= temp_sample;
            new_reg[2] <= noise_sample;
        end
    end

    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_chan
        logic [SUM_W-1:0]      sum_reg, sum_next;
        logic [SQ_W-1:0]       sumsq_reg, sumsq_next;
        sample_t               old_s;
        logic [2*SAMPLE_W-1:0] old_sq, new_sq;
        logic [SQ_W-1:0]       div_value;
        logic [SQ_W-1:0]       quo;
        logic [L-1:0]          rem;
        sample_t               qs_now;
        logic [SUM_W-1:0]      qs_w;
        logic [SUM_W-1:0]      rs_diff;
        sample_t               qs_reg;
        logic [L-1:0]          rs_reg;
        mean_t                 mean_reg;
        logic [2*SAMPLE_W-1:0] qsq_reg;
        logic [SAMPLE_W+L-1:0] qsrs_reg;
        logic [SQ_W-1:0]       t_val;
        logic [2*L-1:0]        w_rt, rs_sq;
        logic [SQ_W-1:0]       var_full;

        assign old_s      = old_valid_reg ? rdata[c*SAMPLE_W +: SAMPLE_W] : '0;
        assign old_sq     = old_s * old_s;
        assign new_sq     = new_reg[c] * new_reg[c];
        assign sum_next   = sum_reg - SUM_W'(old_s) + SUM_W'(new_reg[c]);
        assign sumsq_next = sumsq_reg - SQ_W'(old_sq) + SQ_W'(new_sq);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sum_reg   <= '0;
                sumsq_reg <= '0;
            end
            else if (cmd.update)
            begin
                sum_reg   <= sum_next;
                sumsq_reg <= sumsq_next;
            end
        end

        assign t_val = sumsq_reg - SQ_W'(qsq_reg) * SQ_W'(WINDOW)
                       - (SQ_W'(qsrs_reg) << 1);
        assign div_value = cmd.t_load ? t_val : SQ_W'({sum_next, {FRAC_W{1'b0}}});

        wmv_cdiv #(
            .DIVISOR (WINDOW),
            .NUM_W   (SQ_W)
        ) u_div (
            .clk        (clk),
            .load       (cmd.update | cmd.t_load),
            .step       (cmd.div_step),
            .load_value (div_value),
            .quotient   (quo),
            .remainder  (rem)
        );

        assign qs_now  = quo[MEAN_W-1:FRAC_W];
        assign qs_w    = SUM_W'(qs_now) * SUM_W'(WINDOW);
        assign rs_diff = sum_reg - qs_w;

        assign w_rt     = (2*L)'(WINDOW) * (2*L)'(rem);
        assign rs_sq    = (2*L)'(rs_reg) * (2*L)'(rs_reg);
        assign var_full = (w_rt < rs_sq) ? quo - 1'b1 : quo;

        always_ff @(posedge clk)
        begin
            if (cmd.qr_load)
            begin
                mean_reg <= quo[MEAN_W-1:0];
                qs_reg   <= qs_now;
                rs_reg   <= rs_diff[L-1:0];
            end
            if (cmd.sq_load)
            begin
                qsq_reg  <= qs_reg * qs_reg;
                qsrs_reg <= qs_reg * rs_reg;
            end
            if (cmd.out_load)
            begin
                mean_out_reg[c] <= mean_reg;
                var_out_reg[c]  <= var_full[VAR_W-1:0];
            end
        end
    end

    assign light_mean     = mean_out_reg[0];
    assign temp_mean      = mean_out_reg[1];
    assign noise_mean     = mean_out_reg[2];
    assign light_variance = var_out_reg[0];
    assign temp_variance  = var_out_reg[1];
    assign noise_variance = var_out_reg[2];

endmodule

[hdl/windowed_mean_variance.sv]
// Sliding-window mean and population variance of three 16-bit channels (light, temperature,
// noise) over the last WINDOW transactions; the window starts as zeros, so early results count
// those zeros and the divisor is always WINDOW. Means carry 8 fraction bits, variances are
// floored integers. One transaction is worked at a time. Each channel has a divide-by-WINDOW
// unit, which retires 8 quotient bits per cycle and runs once for the mean and once for the
// variance. A finished result waits in an output register, so the next transaction is taken
// while it is pending.
module windowed_mean_variance #(
    parameter int WINDOW = 20
) (
    input logic       clk,
    input logic       rst_n,
    wmv_in_if.sink    samples,
    wmv_out_if.source results
);
    import wmv_pkg::*;

    wmv_cmd_t cmd;
    logic     in_ready;
    logic     out_valid;

    wmv_ctrl #(
        .WINDOW (WINDOW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (results.ready),
        .cmd       (cmd)
    );

    wmv_dp #(
        .WINDOW (WINDOW)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .light_sample   (samples.light_sample),
        .temp_sample    (samples.temp_sample),
        .noise_sample   (samples.noise_sample),
        .light_mean     (results.light_mean),
        .temp_mean      (results.temp_mean),
        .noise_mean     (results.noise_mean),
        .light_variance (results.light_variance),
        .temp_variance  (results.temp_variance),
        .noise_variance (results.noise_variance)
    );

    assign samples.ready = in_ready;
    assign results.valid = out_valid;

endmodule
